// ===== sv/fdtdil_pkg.sv =====
// Shared types and constants for the incident-line update block.
package fdtdil_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int ROWS_CFG_W  = 11;
  localparam int PLANE_CFG_W = 10;
  localparam int CFG_DATA_W  = 11;
  localparam int MIN_ROWS    = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t Q_MAX = sample_t'(24'sh7FFFFF);
  localparam sample_t Q_MIN = sample_t'(24'sh800000);

  localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = 11'd1024;
  localparam logic [PLANE_CFG_W-1:0] PLANE_RESET = 10'd1;

  typedef enum logic {
    KIND_ELEC = 1'b0,
    KIND_MAG  = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_ROWS  = 1'b0,
    REG_PLANE = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

// ===== sv/fdtdil_ram.sv =====
// Simple dual-port line memory: one write port, one registered read port.
module fdtdil_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  fdtdil_pkg::sample_t        wdata,
  input  logic [AW-1:0]              raddr,
  output fdtdil_pkg::sample_t        rdata
);
  import fdtdil_pkg::*;

  sample_t mem [DEPTH];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fdtdil_upd.sv =====
// Leapfrog update cell: base + floor((a - b) / 2), saturated to Q3.20.
module fdtdil_upd (
  input  fdtdil_pkg::sample_t base,
  input  fdtdil_pkg::sample_t a,
  input  fdtdil_pkg::sample_t b,
  output fdtdil_pkg::sample_t res
);
  import fdtdil_pkg::*;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W-1:0] half_diff;
  logic signed [SAMPLE_W:0]   sum;

  always_comb begin
    diff      = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    half_diff = diff[SAMPLE_W:1];  // arithmetic shift right by one
    sum       = {base[SAMPLE_W-1], base} + {half_diff[SAMPLE_W-1], half_diff};
    priority if (sum[SAMPLE_W] == 1'b0 && sum[SAMPLE_W-1] == 1'b1) begin
      res = Q_MAX;
    end else if (sum[SAMPLE_W] == 1'b1 && sum[SAMPLE_W-1] == 1'b0) begin
      res = Q_MIN;
    end else begin
      res = sum[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== sv/fdtd_incident_line_update.sv =====
// Per item: input beat in idle, n sweep rows, drain, finish; n = rows in use clamped to [5, MAX_ROWS].
// One item at a time: in_stall stays high until the block is back in idle. The sweep reads
// one row per cycle from each line memory.
// A held result stalls the next item only in the finish state, while it waits for the output reg.
// Reset (synchronous, active low) starts a clearing pass over all MAX_ROWS rows that zeroes both
// line memories; in_stall stays high during it, configuration writes are taken as usual.
module fdtd_incident_line_update #(
  parameter int MAX_ROWS   = 1024,
  parameter int SOURCE_ROW = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  fdtdil_pkg::sample_t                   in_source_sample,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output fdtdil_pkg::sample_t                   out_plane_correction,
  output logic                                  out_step_kind,
  // configuration
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_idx,
  input  logic [fdtdil_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fdtdil_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int CW = (NW > ROWS_CFG_W) ? NW : ROWS_CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ROWS_CFG_W-1:0]  rows_in_use_r;
  logic [PLANE_CFG_W-1:0] plane_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      plane_row_r   <= PLANE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROWS:  rows_in_use_r <= cfg_wdata[ROWS_CFG_W-1:0];
        REG_PLANE: plane_row_r   <= cfg_wdata[PLANE_CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  // Effective row count, last row and plane, clamped into the usable range.
  logic [CW-1:0] rows_ext, n_eff, last_eff, plane_ext, plane_eff;
  logic          src_en;

  always_comb begin
    rows_ext = CW'(rows_in_use_r);
    priority if (rows_ext > CW'(MAX_ROWS)) begin
      n_eff = CW'(MAX_ROWS);
    end else if (rows_ext < CW'(MIN_ROWS)) begin
      n_eff = CW'(MIN_ROWS);
    end else begin
      n_eff = rows_ext;
    end
    last_eff  = n_eff - CW'(1);
    plane_ext = CW'(plane_row_r);
    priority if (plane_ext < CW'(1)) begin
      plane_eff = CW'(1);
    end else if (plane_ext > last_eff) begin
      plane_eff = last_eff;
    end else begin
      plane_eff = plane_ext;
    end
    src_en = CW'(SOURCE_ROW) < n_eff;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t        state_r, state_nxt;
  logic [AW-1:0] k_r;         // row being issued to the memories
  logic [AW-1:0] clr_r;       // clearing pass pointer
  logic [AW-1:0] last_r;
  logic [AW-1:0] plane_r;
  logic          src_en_r;
  kind_t         kind_r;
  sample_t       src_r;

  logic          d_vld_r;     // memory data stage valid
  logic [AW-1:0] d_k_r;

  logic          in_acc;
  logic          out_free;
  logic          out_valid_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(MAX_ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_RUN;
      ST_RUN:   if (k_r == last_r) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      k_r     <= '0;
      d_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      d_vld_r <= (state_r == ST_RUN);
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == ST_RUN) begin
        k_r <= k_r + AW'(1);
      end else begin
        k_r <= '0;
      end
    end
  end

  // Per-item settings, captured at the input beat
  always_ff @(posedge clk) begin
    d_k_r <= k_r;
    if (in_acc) begin
      kind_r   <= kind_t'(in_kind);
      src_r    <= in_source_sample;
      last_r   <= AW'(last_eff);
      plane_r  <= AW'(plane_eff);
      src_en_r <= src_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories. The updated line is written at most once per row in a sweep,
  // the write using the registered row index d_k_r, so a read never meets a
  // pending write to the same row; items do not overlap.
  // ---------------------------------------------------------------------------
  logic          clearing;
  logic          e_we, h_we;
  logic [AW-1:0] e_waddr, h_waddr, e_raddr, h_raddr;
  sample_t       e_wdata, h_wdata, e_rd, h_rd;

  assign clearing = (state_r == ST_CLEAR);

  // Magnetic sweep reads H one row behind E: H[k-1] pairs with E[k-1], E[k].
  assign e_raddr = k_r;
  assign h_raddr = (kind_r == KIND_MAG && k_r != '0) ? k_r - AW'(1) : k_r;

  fdtdil_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rd)
  );

  fdtdil_ram #(.DEPTH(MAX_ROWS), .AW(AW)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rd)
  );

  // ---------------------------------------------------------------------------
  // Update datapath. Both half steps share one cell:
  //   electric: E[k]   += half(H[k-1] - H[k])
  //   magnetic: H[k-1] += half(E[k-1] - E[k])
  // prev_r holds the neighbor line's sample from the previous row.
  // ---------------------------------------------------------------------------
  sample_t prev_r;
  sample_t upd_base, upd_b, upd_res;
  sample_t e_new;

  assign upd_base = (kind_r == KIND_ELEC) ? e_rd : h_rd;
  assign upd_b    = (kind_r == KIND_ELEC) ? h_rd : e_rd;

  fdtdil_upd u_upd (
    .base (upd_base),
    .a    (prev_r),
    .b    (upd_b),
    .res  (upd_res)
  );

  // Absorbing-boundary delay taps
  sample_t lo_d1_r, lo_d2_r, hi_d1_r, hi_d2_r;
  sample_t e_row1_r, e_rown2_r;   // new E[1], E[n-2] of this sweep
  sample_t corr_r;

  // Boundary rows take the delayed values; the high end wins over the source.
  always_comb begin
    priority if (d_k_r == '0) begin
      e_new = lo_d2_r;
    end else if (d_k_r == last_r) begin
      e_new = hi_d2_r;
    end else if (src_en_r && d_k_r == AW'(SOURCE_ROW)) begin
      e_new = src_r;
    end else begin
      e_new = upd_res;
    end
  end

  assign e_we    = clearing || (d_vld_r && kind_r == KIND_ELEC);
  assign e_waddr = clearing ? clr_r : d_k_r;
  assign e_wdata = clearing ? '0 : e_new;

  assign h_we    = clearing || (d_vld_r && kind_r == KIND_MAG && d_k_r != '0);
  assign h_waddr = clearing ? clr_r : d_k_r - AW'(1);
  assign h_wdata = clearing ? '0 : upd_res;

  always_ff @(posedge clk) begin
    if (d_vld_r) begin
      prev_r <= upd_b;
      if (kind_r == KIND_ELEC) begin
        if (d_k_r == AW'(1))          e_row1_r  <= e_new;
        if (d_k_r == last_r - AW'(1)) e_rown2_r <= e_new;
        // half of H just below the plane
        if (d_k_r == plane_r - AW'(1)) corr_r <= {h_rd[SAMPLE_W-1], h_rd[SAMPLE_W-1:1]};
      end else begin
        // half of E at the plane
        if (d_k_r == plane_r) corr_r <= {e_rd[SAMPLE_W-1], e_rd[SAMPLE_W-1:1]};
      end
    end
  end

  // Delay line shifts once per electric step, after row n-1 took hi_d2_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_d1_r <= '0;
      lo_d2_r <= '0;
      hi_d1_r <= '0;
      hi_d2_r <= '0;
    end else if (state_r == ST_DRAIN && kind_r == KIND_ELEC) begin
      lo_d2_r <= lo_d1_r;
      lo_d1_r <= e_row1_r;
      hi_d2_r <= hi_d1_r;
      hi_d1_r <= e_rown2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  sample_t out_corr_r;
  logic    out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_corr_r <= corr_r;
      out_kind_r <= kind_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_plane_correction = out_corr_r;
  assign out_step_kind        = out_kind_r;

endmodule

// ===== sv/fdtdil_chk.sv =====
// Port-level checker for the incident-line update block, with its bind.
module fdtdil_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fdtdil_pkg::sample_t out_plane_correction,
  input logic                out_step_kind
);
  import fdtdil_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plane_correction)
      && $stable(out_step_kind))
    else $error("result dropped or changed while stalled");

  // reset starts the clearing pass, no input taken
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // one item at a time: busy right after an input beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall)
    else $error("second input beat taken before sweep");

  // a sweep takes at least five rows, so no result appears right after a beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after input beat");

endmodule

bind fdtd_incident_line_update fdtdil_chk u_fdtdil_chk (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the incident-line half-step update block.
`timescale 1ns / 1ps

module tb_top;
  import fdtdil_pkg::*;

  // Block parameters; the line predictor below uses the same values.
  localparam int TB_MAX_ROWS   = 1024;
  localparam int TB_SOURCE_ROW = 3;

  // Worst case: ~600 beats at full line length plus every stall and gap stays
  // well under this limit; the real run is far below that.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Longest sweep with some margin, used for the final quiet wait.
  localparam int TAIL_CYCLES = 1100;

  // One expected result beat.
  typedef struct {
    sample_t corr;
    kind_t   kind;
  } plane_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  sample_t               in_source_sample;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               out_plane_correction;
  logic                  out_step_kind;
  logic                  cfg_we;
  logic [0:0]            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fdtd_incident_line_update #(
    .MAX_ROWS   (TB_MAX_ROWS),
    .SOURCE_ROW (TB_SOURCE_ROW)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_source_sample     (in_source_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_plane_correction (out_plane_correction),
    .out_step_kind        (out_step_kind),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Line predictor: private copy of both field lines, the boundary history and
  // the two registers. Advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  sample_t               ez_line [TB_MAX_ROWS];
  sample_t               hy_line [TB_MAX_ROWS];
  sample_t               lo_hist [2];   // [0] newest, [1] two steps old
  sample_t               hi_hist [2];
  logic [ROWS_CFG_W-1:0]  rows_cfg;
  logic [PLANE_CFG_W-1:0] plane_cfg;

  plane_result_t pending_corrections[$];

  // Run bookkeeping
  int  errors;
  int  cycle_count;
  int  elec_beats;
  int  mag_beats;
  int  results_seen;
  int  settings_tried;
  int  sat_hits;
  bit  calm;        // no idling on either side
  int  send_pct;    // chance in percent of a gap before an input beat
  int  stall_pct;   // chance in percent per cycle of a result stall burst

  function automatic int rows_effective(input int r);
    if (r > TB_MAX_ROWS) return TB_MAX_ROWS;
    if (r < MIN_ROWS) return MIN_ROWS;
    return r;
  endfunction

  // Saturate a wide sum to the Q3.20 range.
  function automatic sample_t clip24(input longint v);
    if (v > longint'(Q_MAX)) begin
      sat_hits++;
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      sat_hits++;
      return Q_MIN;
    end
    return sample_t'(v);
  endfunction

  // Half steps use floor(x/2): arithmetic shift on a signed 64-bit value.
  function automatic plane_result_t step_incident_line(input kind_t k, input sample_t src);
    int unsigned   n;
    int unsigned   p;
    int unsigned   j;
    plane_result_t r;
    n = rows_effective(int'(rows_cfg));
    p = (plane_cfg < 1) ? 1 : plane_cfg;
    if (p > n - 1) p = n - 1;
    r.kind = k;
    if (k == KIND_ELEC) begin
      for (j = 1; j < n; j++)
        ez_line[j] = clip24(longint'(ez_line[j]) +
                            ((longint'(hy_line[j-1]) - longint'(hy_line[j])) >>> 1));
      if (TB_SOURCE_ROW < n) ez_line[TB_SOURCE_ROW] = src;
      // Two-step-delay absorbing ends; the upper end write wins over the source.
      ez_line[0]   = lo_hist[1];
      lo_hist[1]   = lo_hist[0];
      lo_hist[0]   = ez_line[1];
      ez_line[n-1] = hi_hist[1];
      hi_hist[1]   = hi_hist[0];
      hi_hist[0]   = ez_line[n-2];
      r.corr = sample_t'(longint'(hy_line[p-1]) >>> 1);
    end else begin
      for (j = 0; j + 1 < n; j++)
        hy_line[j] = clip24(longint'(hy_line[j]) +
                            ((longint'(ez_line[j]) - longint'(ez_line[j+1])) >>> 1));
      r.corr = sample_t'(longint'(ez_line[p]) >>> 1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_count, pending_corrections.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, off whenever calm is set or the
  // current rate is zero.
  // ---------------------------------------------------------------------------
  initial begin : result_backpressure
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    plane_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_corrections.size() == 0) begin
        $error("unexpected result beat: plane_correction %0d, step_kind %0d",
               out_plane_correction, out_step_kind);
        errors++;
      end else begin
        want = pending_corrections.pop_front();
        if (out_plane_correction !== want.corr) begin
          $error("plane_correction mismatch: expected %0d, actual %0d",
                 want.corr, out_plane_correction);
          errors++;
        end
        if (out_step_kind !== want.kind) begin
          $error("step_kind mismatch: expected %0d, actual %0d", want.kind, out_step_kind);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks. All of them start and end on a rising-edge step.
  // ---------------------------------------------------------------------------

  // Send one half step. Valid stays high after acceptance so that a following
  // beat goes out with no bubble; finish_phase lowers it.
  task automatic send_beat(input kind_t k, input sample_t src);
    int gap;
    if (!calm && $urandom_range(0, 99) < send_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_source_sample <= src;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_corrections.push_back(step_incident_line(k, src));
    if (k == KIND_ELEC) elec_beats++;
    else mag_beats++;
  endtask

  // Close a burst and wait until every expected beat has come back.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  // Write both registers, rows first, then plane; only called while idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] plane);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_idx   <= REG_PLANE;
    cfg_wdata <= plane;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_cfg  = rows[ROWS_CFG_W-1:0];
    plane_cfg = plane[PLANE_CFG_W-1:0];
    settings_tried++;
  endtask

  // Mostly realistic amplitudes (about +-1.0), with rails and raw noise mixed in.
  function automatic sample_t random_source();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic int idle_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers (full line, plane at row 1), rails and zero as source.
  task automatic test_default_settings();
    send_pct  = 10;
    stall_pct = 10;
    send_beat(KIND_ELEC, Q_MAX);
    send_beat(KIND_MAG,  sample_t'(0));
    send_beat(KIND_ELEC, Q_MIN);
    send_beat(KIND_MAG,  Q_MAX);
    finish_phase();
  endtask

  // Register values outside the usable range are clamped by the block.
  task automatic test_clamped_settings();
    set_config(11'd0, 11'd0);          // rows -> 5, plane -> 1
    send_beat(KIND_ELEC, sample_t'(24'h5A5A5A));
    send_beat(KIND_MAG,  sample_t'(24'hA5A5A5));
    finish_phase();
    set_config(11'd4, 11'd1023);       // rows -> 5, plane -> top row 4
    send_beat(KIND_ELEC, Q_MIN);
    send_beat(KIND_MAG,  Q_MIN);
    finish_phase();
    set_config(11'd5, 11'd4);          // smallest legal line, plane at its top
    send_beat(KIND_ELEC, Q_MAX);
    send_beat(KIND_MAG,  sample_t'(-1));
    finish_phase();
    set_config(11'd2047, 11'd1023);    // rows -> MAX_ROWS, plane at the last row
    send_beat(KIND_ELEC, sample_t'(-1));
    send_beat(KIND_MAG,  sample_t'(1));
    finish_phase();
    set_config(11'd1025, 11'h400);     // plane write with only the unused bit set
    send_beat(KIND_MAG,  sample_t'(0));
    finish_phase();
  endtask

  // Repeated same-kind steps pile up differences until both lines hit the rails.
  task automatic test_saturating_fields();
    set_config(11'd6, 11'd2);
    send_beat(KIND_ELEC, Q_MAX);
    repeat (4) send_beat(KIND_MAG, Q_MAX);
    repeat (3) send_beat(KIND_ELEC, Q_MIN);
    repeat (2) send_beat(KIND_MAG, Q_MIN);
    finish_phase();
  endtask

  // Phases with random settings and random idling on both sides. Beats mostly
  // alternate electric/magnetic as a real time-stepping loop would; now and then
  // the same kind repeats. Full-length lines are kept to a few short phases.
  task automatic test_random_traffic(input int beats);
    int    sent;
    int    big_runs;
    int    rows;
    int    plane;
    int    top_plane;
    int    burst_len;
    kind_t k;
    sent     = 0;
    big_runs = 0;
    k        = KIND_MAG;
    while (sent < beats) begin
      case ($urandom_range(0, 15))
        0:       rows = TB_MAX_ROWS;
        1:       rows = $urandom_range(1025, 2047);
        2:       rows = $urandom_range(0, 4);
        default: rows = $urandom_range(5, 48);
      endcase
      if (rows_effective(rows) == TB_MAX_ROWS) begin
        if (big_runs >= 3) rows = $urandom_range(5, 48);
        else big_runs++;
      end
      burst_len = (rows_effective(rows) == TB_MAX_ROWS) ? $urandom_range(2, 6)
                                                        : $urandom_range(8, 32);
      top_plane = rows_effective(rows) - 1;
      if (top_plane > 1023) top_plane = 1023;
      // Mostly a plane inside the line, sometimes anything the field holds.
      plane = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(1, top_plane);
      plane = plane | ($urandom_range(0, 1) << PLANE_CFG_W);
      send_pct  = idle_rate();
      stall_pct = idle_rate();
      set_config(CFG_DATA_W'(rows), CFG_DATA_W'(plane));
      repeat (burst_len) begin
        if ($urandom_range(0, 7) != 0) k = kind_t'(~k);
        send_beat(k, random_source());
        sent++;
      end
      finish_phase();
    end
  endtask

  // Final stretch with no idling at all: back-to-back beats, result never held.
  task automatic test_streaming_tail(input int beats);
    kind_t k;
    k    = KIND_MAG;
    calm = 1'b1;
    set_config(11'($urandom_range(5, 40)), 11'($urandom_range(1, 4)));
    repeat (beats) begin
      k = kind_t'(~k);
      send_beat(k, random_source());
    end
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int j;
    errors         = 0;
    elec_beats     = 0;
    mag_beats      = 0;
    results_seen   = 0;
    settings_tried = 0;
    sat_hits       = 0;
    cycle_count    = 0;
    calm           = 1'b0;
    send_pct       = 0;
    stall_pct      = 0;

    // Predictor starts from the reset state of the block.
    for (j = 0; j < TB_MAX_ROWS; j++) begin
      ez_line[j] = '0;
      hy_line[j] = '0;
    end
    lo_hist   = '{default: '0};
    hi_hist   = '{default: '0};
    rows_cfg  = ROWS_RESET;
    plane_cfg = PLANE_RESET;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_ELEC;
    in_source_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_ROWS;
    cfg_wdata        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass after reset shows up as in_stall; send_beat waits it out.
    test_default_settings();
    test_clamped_settings();
    test_saturating_fields();
    test_random_traffic(500);
    test_streaming_tail(60);

    // Anything arriving now has no expectation and is flagged by the checker.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d electric and %0d magnetic half steps over %0d register settings",
             elec_beats, mag_beats, settings_tried);
    $display("Checked %0d result beats in %0d cycles; %0d saturated sums predicted",
             results_seen, cycle_count, sat_hits);
    if (errors == 0 && pending_corrections.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== fdtd_incident_line_update.f =====
sv/fdtdil_pkg.sv
sv/fdtdil_ram.sv
sv/fdtdil_upd.sv
sv/fdtd_incident_line_update.sv
sv/fdtdil_chk.sv
verif/tb_top.sv
